// File: hw/rtl/underrun_fade_resume_concealer_assert.svh
// Assertion macros for the underrun fade/resume concealer RTL.
`ifndef UNDERRUN_FADE_RESUME_CONCEALER_ASSERT_SVH
`define UNDERRUN_FADE_RESUME_CONCEALER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define UFRC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define UFRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ufrc_pkg.sv
// Shared constants for the underrun fade/resume concealer.
package ufrc_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int RAMP_FRAMES_DEF = 96;

    // Decay factor 65208/65536, about 0.995, as a signed multiplier operand.
    localparam int                 DECAY_BW    = 17;
    localparam logic signed [16:0] DECAY_NUM   = 17'sd65208;
    localparam int                 DECAY_SHIFT = 16;

    // Channel layout codes.
    localparam logic [1:0] LAYOUT_MONO   = 2'd0;
    localparam logic [1:0] LAYOUT_STEREO = 2'd1;
    localparam logic [1:0] LAYOUT_WIDE   = 2'd2;
    localparam logic [1:0] LAYOUT_RESET  = LAYOUT_STEREO;

    // Configuration port geometry and register index.
    localparam int   APB_DW         = 32;
    localparam int   APB_AW         = 3;
    localparam logic CFG_IDX_LAYOUT = 1'b0;

endpackage

// File: hw/rtl/ufrc_apb.sv
// Configuration register file holding the channel layout.
module ufrc_apb (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ufrc_pkg::APB_AW-1:0]    paddr,
    input  logic [ufrc_pkg::APB_DW-1:0]    pwdata,
    output logic [ufrc_pkg::APB_DW-1:0]    prdata,
    output logic                           pready,
    output logic [1:0]                     o_layout
);

    logic [1:0] r_layout;
    logic       w_hit;

    // Word index is paddr[2]; the byte offset bits are ignored.
    assign w_hit  = (paddr[2] == ufrc_pkg::CFG_IDX_LAYOUT);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout <= ufrc_pkg::LAYOUT_RESET;
        end else if (psel && penable && pwrite && w_hit) begin
            r_layout <= pwdata[1:0];
        end
    end

    assign prdata   = w_hit ? ufrc_pkg::APB_DW'(r_layout) : '0;
    assign o_layout = r_layout;

endmodule

// File: hw/rtl/ufrc_mul.sv
// Shared signed multiplier with a registered product.
module ufrc_mul #(
    parameter int AW = 17,
    parameter int BW = 17
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [AW-1:0]        i_a,
    input  logic signed [BW-1:0]        i_b,
    output logic signed [AW+BW-1:0]     o_p
);

    logic signed [AW+BW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= (AW+BW)'(i_a) * (AW+BW)'(i_b);
        end
    end

    assign o_p = r_p;

endmodule

// File: hw/rtl/underrun_fade_resume_concealer.sv
// Top level of the underrun fade/resume concealer: sequencer and datapath.
//
//  Channel   | Direction | Handshake               | Contents
//  ----------+-----------+-------------------------+------------------------------------
//  s_axis    | in        | tvalid / tready         | tdata {right_in, left_in}, tuser
//            |           |                         | has_sample, tlast burst_last
//  m_axis    | out       | tvalid / tready         | tdata {second_out, first_out}, tuser
//            |           |                         | used_filler, tlast burst_end
//  APB       | in/out    | psel, penable, pready   | register 0 channel_layout
//
// One transaction is worked on at a time; s_axis tready is high only in idle. A real
// frame with no ramp pending goes straight to the output step, a filler frame takes one
// decay multiply per channel, a blended frame per channel a multiply by the ramp count,
// then one by the reciprocal of RAMP_FRAMES in place of a division. Reset is synchronous
// and active low; it clears the held frame, the ramp and the output valid and sets the
// layout to stereo. A finished result waits in the output register, so the next
// transaction is accepted while it stalls.
`include "underrun_fade_resume_concealer_assert.svh"

module underrun_fade_resume_concealer #(
    parameter int SAMPLE_BITS = ufrc_pkg::SAMPLE_BITS_DEF,
    parameter int RAMP_FRAMES = ufrc_pkg::RAMP_FRAMES_DEF,
    localparam int DW = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input frame request.
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [DW-1:0]                  i_s_axis_tdata,  // left_in, right_in, zero pad
    input  logic                           i_s_axis_tuser,  // has_sample
    input  logic                           i_s_axis_tlast,  // burst_last
    // Output frame.
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [DW-1:0]                  o_m_axis_tdata,  // first_out, second_out, zero pad
    output logic                           o_m_axis_tuser,  // used_filler
    output logic                           o_m_axis_tlast,  // burst_end
    // Configuration port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ufrc_pkg::APB_AW-1:0]    paddr,
    input  logic [ufrc_pkg::APB_DW-1:0]    pwdata,
    output logic [ufrc_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);

    localparam int SB  = SAMPLE_BITS;
    localparam int CW  = $clog2(RAMP_FRAMES + 1);   // ramp counter width
    localparam int MW  = SB + CW + 1;               // dividend and quotient width
    // Division by RAMP_FRAMES is a multiply by ceil(2^RK / RAMP_FRAMES) and a shift
    // by RK; the error of the rounded-up reciprocal stays below one quotient step
    // for every dividend under 2^MW.
    localparam int     RK    = MW + $clog2(RAMP_FRAMES);
    localparam longint RECIP = ((longint'(1) << RK) + RAMP_FRAMES - 1) / RAMP_FRAMES;
    localparam int     RBW   = $clog2(RECIP + 1);
    localparam int  AW  = MW + 1;                   // multiplier operand A
    localparam int  BW  = (RBW + 1 > ufrc_pkg::DECAY_BW) ? RBW + 1
                                                         : ufrc_pkg::DECAY_BW;
    localparam int  PW  = AW + BW;                  // product width

    localparam logic [CW-1:0]      RAMP_INIT = CW'(RAMP_FRAMES);
    localparam logic signed [BW-1:0] RECIP_B = BW'(RECIP);
    localparam logic [MW-1:0]      HALF      = MW'(RAMP_FRAMES / 2);
    localparam logic signed [MW:0] SAT_HI   = {{(MW + 2 - SB){1'b0}}, {(SB - 1){1'b1}}};
    localparam logic signed [MW:0] SAT_LO   = {{(MW + 2 - SB){1'b1}}, {(SB - 1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_POST,
        S_DIV,
        S_FIN,
        S_OUT
    } t_state;

    t_state                r_state,   n_state;
    logic                  r_ch,      n_ch;
    logic                  r_fill,    n_fill;
    logic                  r_last,    n_last;
    logic signed [SB-1:0]  r_in_l,    n_in_l;
    logic signed [SB-1:0]  r_in_r,    n_in_r;
    logic signed [SB-1:0]  r_held_l,  n_held_l;
    logic signed [SB-1:0]  r_held_r,  n_held_r;
    logic [CW-1:0]         r_ramp,    n_ramp;
    logic                  r_neg,     n_neg;
    logic [MW-1:0]         r_dvd,     n_dvd;
    logic                  r_ovalid,  n_ovalid;
    logic signed [SB-1:0]  r_o_first, n_o_first;
    logic signed [SB-1:0]  r_o_second, n_o_second;
    logic                  r_o_fill,  n_o_fill;
    logic                  r_o_last,  n_o_last;

    logic [1:0]            w_layout;
    logic                  w_in_acc;
    logic signed [SB-1:0]  w_held_sel;
    logic signed [SB-1:0]  w_in_sel;
    logic signed [AW-1:0]  w_ma;
    logic signed [BW-1:0]  w_mb;
    logic signed [PW-1:0]  w_p;
    logic                  w_pneg;
    logic [PW-1:0]         w_pabs;
    logic signed [SB-1:0]  w_dmag;
    logic signed [SB-1:0]  w_dec;
    logic [MW-1:0]         w_quo;
    logic signed [MW:0]    w_qs;
    logic signed [MW:0]    w_sum;
    logic signed [SB-1:0]  w_blend;
    logic signed [SB:0]    w_mix;

    ufrc_apb u_apb (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_layout (w_layout)
    );

    // The one multiplier serves the decay, the blend product and the division.
    ufrc_mul #(
        .AW (AW),
        .BW (BW)
    ) u_mul (
        .i_clk (i_clk),
        .i_en  ((r_state == S_MUL) || (r_state == S_DIV)),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_p)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    // Channel currently being processed: left first, then right.
    assign w_held_sel = r_ch ? r_held_r : r_held_l;
    assign w_in_sel   = r_ch ? r_in_r : r_in_l;

    // Filler multiplies the held sample by the decay factor; a real frame
    // multiplies the difference to the held sample by the ramp count. In the
    // division step the rounded dividend meets the reciprocal.
    assign w_ma = (r_state == S_DIV) ? $signed({1'b0, r_dvd})
                : r_fill ? $signed({{(AW - SB){w_held_sel[SB-1]}}, w_held_sel})
                         : $signed({{(AW - SB){w_held_sel[SB-1]}}, w_held_sel})
                           - $signed({{(AW - SB){w_in_sel[SB-1]}}, w_in_sel});
    assign w_mb = (r_state == S_DIV) ? RECIP_B
                : r_fill ? $signed(BW'(ufrc_pkg::DECAY_NUM)) : $signed(BW'(r_ramp));

    // Decay rounds toward zero by shifting the magnitude.
    assign w_pneg = w_p[PW-1];
    assign w_pabs = w_pneg ? PW'(-w_p) : PW'(w_p);
    assign w_dmag = $signed(w_pabs[ufrc_pkg::DECAY_SHIFT +: SB]);
    assign w_dec  = w_pneg ? -w_dmag : w_dmag;

    // Quotient of the rounded magnitude by RAMP_FRAMES.
    assign w_quo = MW'(w_p[PW-1:RK]);

    // Signed, rounded quotient added to the input sample, then saturated.
    assign w_qs    = r_neg ? -$signed({1'b0, w_quo}) : $signed({1'b0, w_quo});
    assign w_sum   = $signed({{(MW + 1 - SB){w_in_sel[SB-1]}}, w_in_sel}) + w_qs;
    assign w_blend = (w_sum > SAT_HI) ? SAT_HI[SB-1:0]
                   : (w_sum < SAT_LO) ? SAT_LO[SB-1:0]
                   : w_sum[SB-1:0];

    // Mono downmix is the floor of half the sum.
    assign w_mix = $signed({r_held_l[SB-1], r_held_l}) + $signed({r_held_r[SB-1], r_held_r});

    always_comb begin
        n_state    = r_state;
        n_ch       = r_ch;
        n_fill     = r_fill;
        n_last     = r_last;
        n_in_l     = r_in_l;
        n_in_r     = r_in_r;
        n_held_l   = r_held_l;
        n_held_r   = r_held_r;
        n_ramp     = r_ramp;
        n_neg      = r_neg;
        n_dvd      = r_dvd;
        n_ovalid   = r_ovalid && !i_m_axis_tready;
        n_o_first  = r_o_first;
        n_o_second = r_o_second;
        n_o_fill   = r_o_fill;
        n_o_last   = r_o_last;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_ch   = 1'b0;
                    n_fill = !i_s_axis_tuser;
                    n_last = i_s_axis_tlast;
                    n_in_l = $signed(i_s_axis_tdata[SB-1:0]);
                    n_in_r = $signed(i_s_axis_tdata[2*SB-1:SB]);
                    if (!i_s_axis_tuser) begin
                        n_ramp  = RAMP_INIT;
                        n_state = S_MUL;
                    end else if (r_ramp != '0) begin
                        n_state = S_MUL;
                    end else begin
                        // Real frame with no ramp pending passes straight through.
                        n_held_l = $signed(i_s_axis_tdata[SB-1:0]);
                        n_held_r = $signed(i_s_axis_tdata[2*SB-1:SB]);
                        n_state  = S_OUT;
                    end
                end
            end
            S_MUL: begin
                n_state = S_POST;
            end
            S_POST: begin
                if (r_fill) begin
                    if (r_ch) begin
                        n_held_r = w_dec;
                        n_state  = S_OUT;
                    end else begin
                        n_held_l = w_dec;
                        n_ch     = 1'b1;
                        n_state  = S_MUL;
                    end
                end else begin
                    n_neg   = w_pneg;
                    n_dvd   = w_pabs[MW-1:0] + HALF;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (r_ch) begin
                    n_held_r = w_blend;
                    n_ramp   = r_ramp - 1'b1;
                    n_state  = S_OUT;
                end else begin
                    n_held_l = w_blend;
                    n_ch     = 1'b1;
                    n_state  = S_MUL;
                end
            end
            S_OUT: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_o_fill = r_fill;
                    n_o_last = r_last;
                    if (w_layout == ufrc_pkg::LAYOUT_MONO) begin
                        n_o_first  = w_mix[SB:1];
                        n_o_second = '0;
                    end else begin
                        n_o_first  = r_held_l;
                        n_o_second = r_held_r;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_held_l <= '0;
            r_held_r <= '0;
            r_ramp   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_held_l <= n_held_l;
            r_held_r <= n_held_r;
            r_ramp   <= n_ramp;
            r_ovalid <= n_ovalid;
        end
        r_ch       <= n_ch;
        r_fill     <= n_fill;
        r_last     <= n_last;
        r_in_l     <= n_in_l;
        r_in_r     <= n_in_r;
        r_neg      <= n_neg;
        r_dvd      <= n_dvd;
        r_o_first  <= n_o_first;
        r_o_second <= n_o_second;
        r_o_fill   <= n_o_fill;
        r_o_last   <= n_o_last;
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = DW'({r_o_second, r_o_first});
    assign o_m_axis_tuser  = r_o_fill;
    assign o_m_axis_tlast  = r_o_last;

    // The sequencer must leave idle after taking a transaction.
    `UFRC_ASSERT_NEXT(a_busy_after_accept, w_in_acc, !o_s_axis_tready, "ready stayed high after accept")
    // A filler request arms the full resume ramp.
    `UFRC_ASSERT_NEXT(a_filler_arms_ramp, w_in_acc && !i_s_axis_tuser, r_ramp == RAMP_INIT, "filler did not arm ramp")
    // The ramp count never exceeds its armed length.
    `UFRC_ASSERT_SAME(a_ramp_bounded, 1'b1, r_ramp <= RAMP_INIT, "ramp count above ramp length")

endmodule
